// ===== hdl/masked_3x3_morphology_filter_unit_defines.svh =====
// Assertion macros used by the morphology filter checker
`ifndef MASKED_3X3_MORPHOLOGY_FILTER_UNIT_DEFINES_SVH
`define MASKED_3X3_MORPHOLOGY_FILTER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define MMF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define MMF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/mmf_pkg.sv =====
// Types, constants and mask decode for the masked 3x3 morphology filter
package mmf_pkg;

  localparam int PIX_IO_W   = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int MODE_W     = 2;
  localparam int MASK_W     = 3;
  localparam int LINE_LEN_W = 11;
  localparam int FRAME_H_W  = 16;
  localparam int MIN_GEOM   = 3;
  localparam int WIN_TAPS   = 9;
  localparam int CENTER_TAP = 4;

  typedef enum logic [MODE_W-1:0] {
    MODE_ERODE  = 2'd0,
    MODE_DILATE = 2'd1,
    MODE_INNER  = 2'd2,
    MODE_OUTER  = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE   = 3'd0,
    CFG_MASK   = 3'd1,
    CFG_FILL   = 3'd2,
    CFG_LENGTH = 3'd3,
    CFG_HEIGHT = 3'd4
  } cfg_idx_t;

  localparam logic [MASK_W-1:0] MASK_VBAR  = 3'd1;
  localparam logic [MASK_W-1:0] MASK_HBAR  = 3'd2;
  localparam logic [MASK_W-1:0] MASK_CROSS = 3'd3;

  localparam mode_t                  RST_MODE   = MODE_ERODE;
  localparam logic [MASK_W-1:0]      RST_MASK   = 3'd4;
  localparam logic [CFG_DATA_W-1:0]  RST_FILL   = 16'd255;
  localparam logic [LINE_LEN_W-1:0]  RST_LENGTH = 11'd512;
  localparam logic [FRAME_H_W-1:0]   RST_HEIGHT = 16'd512;

  // Per-item position flags that travel down the pipeline
  typedef struct packed {
    logic emit;
    logic border;
    logic last;
  } pos_info_t;

  // Tap enables of the window, bit k is window position k (row-major)
  function automatic logic [WIN_TAPS-1:0] mask_bits(input logic [MASK_W-1:0] shape);
    logic [WIN_TAPS-1:0] m;
    unique case (shape)
      MASK_VBAR:  m = 9'b010_010_010;
      MASK_HBAR:  m = 9'b000_111_000;
      MASK_CROSS: m = 9'b010_111_010;
      default:    m = 9'b111_111_111;
    endcase
    return m;
  endfunction

endpackage

// ===== hdl/mmf_pixel_in_if.sv =====
// Input pixel channel: valid/ready with pixel and pad flag
interface mmf_pixel_in_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [mmf_pkg::PIX_IO_W-1:0]     pixel_in;
  logic                                    pad;

  modport source (output valid, output pixel_in, output pad, input ready);
  modport sink   (input valid, input pixel_in, input pad, output ready);
endinterface

// ===== hdl/mmf_pixel_out_if.sv =====
// Result pixel channel: valid/ready with filtered pixel and frame end flag
interface mmf_pixel_out_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [mmf_pkg::PIX_IO_W-1:0]     pixel_out;
  logic                                    frame_end;

  modport source (output valid, output pixel_out, output frame_end, input ready);
  modport sink   (input valid, input pixel_out, input frame_end, output ready);
endinterface

// ===== hdl/masked_3x3_morphology_filter_unit.sv =====
// Top level of the masked 3x3 morphology filter
//
//  channel   dir  payload                          handshake
//  in_px     in   pixel_in[15:0] signed, pad       valid/ready
//  out_px    out  pixel_out[15:0] signed, frame_end valid/ready
//  cfg_*     in   cfg_idx[2:0], cfg_wdata[15:0]    cfg_we, no stall
//
// One beat per cycle while no held result blocks out_px; each beat passes an input register
// (with the row store read), the window register and the output register before its
// result shows on out_px.
// in_px.ready falls only while a held result blocks the output register.
// Reset is synchronous on rst_n; the row stores are not cleared.
module masked_3x3_morphology_filter_unit #(
  parameter int MAX_LINE   = 1024,
  parameter int PIXEL_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  mmf_pixel_in_if.sink                           in_px,
  mmf_pixel_out_if.source                        out_px,
  input  logic                                   cfg_we,
  input  logic [mmf_pkg::CFG_IDX_W-1:0]          cfg_idx,
  input  logic [mmf_pkg::CFG_DATA_W-1:0]         cfg_wdata
);

  localparam int COL_W = $clog2(MAX_LINE);
  localparam int OW    = mmf_pkg::PIX_IO_W;

  // Configuration registers
  mmf_pkg::mode_t                    mode_r;
  logic [mmf_pkg::MASK_W-1:0]        mask_r;
  logic [mmf_pkg::CFG_DATA_W-1:0]    fill_r;
  logic [mmf_pkg::LINE_LEN_W-1:0]    len_r;
  logic [mmf_pkg::FRAME_H_W-1:0]     hgt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= mmf_pkg::RST_MODE;
      mask_r <= mmf_pkg::RST_MASK;
      fill_r <= mmf_pkg::RST_FILL;
      len_r  <= mmf_pkg::RST_LENGTH;
      hgt_r  <= mmf_pkg::RST_HEIGHT;
    end else if (cfg_we) begin
      unique case (mmf_pkg::cfg_idx_t'(cfg_idx))
        mmf_pkg::CFG_MODE:   mode_r <= mmf_pkg::mode_t'(cfg_wdata[mmf_pkg::MODE_W-1:0]);
        mmf_pkg::CFG_MASK:   mask_r <= cfg_wdata[mmf_pkg::MASK_W-1:0];
        mmf_pkg::CFG_FILL:   fill_r <= cfg_wdata;
        mmf_pkg::CFG_LENGTH: len_r  <= cfg_wdata[mmf_pkg::LINE_LEN_W-1:0];
        mmf_pkg::CFG_HEIGHT: hgt_r  <= cfg_wdata[mmf_pkg::FRAME_H_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control
  logic                          s1_v_r, s1_v_nxt, s2_v_r, s2_v_nxt;
  logic                          out_v_r, out_v_nxt;
  logic                          out_ok, s2_free, s1_free, accept, s1_go, s2_go;
  logic [COL_W-1:0]              s1_col_r, seq_col;
  logic signed [PIXEL_BITS-1:0]  s1_px_r, in_px_w, top_px, mid_px;
  mmf_pkg::pos_info_t            seq_info, s1_info_r, s2_info_r;
  logic signed [OW-1:0]          out_px_r, kern_res;
  logic                          out_end_r;

  assign out_ok  = !out_v_r || out_px.ready;
  assign s2_free = !s2_v_r || out_ok;
  assign s1_free = !s1_v_r || s2_free;
  assign accept  = in_px.valid && s1_free;
  assign s1_go   = s1_v_r && s2_free;
  assign s2_go   = s2_v_r && out_ok;
  assign in_px.ready = s1_free;

  // Pad beats carry a zero pixel
  assign in_px_w = in_px.pad ? '0 : in_px.pixel_in[PIXEL_BITS-1:0];

  always_comb begin
    s1_v_nxt  = accept ? 1'b1 : (s1_go ? 1'b0 : s1_v_r);
    s2_v_nxt  = s1_go ? 1'b1 : (s2_go ? 1'b0 : s2_v_r);
    out_v_nxt = out_ok ? (s2_go && s2_info_r.emit) : out_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      s2_v_r  <= s2_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Hold beat payload and position flags per stage
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px_r   <= in_px_w;
      s1_col_r  <= seq_col;
      s1_info_r <= seq_info;
    end
    if (s1_go) begin
      s2_info_r <= s1_info_r;
    end
    if (s2_go) begin
      out_px_r  <= kern_res;
      out_end_r <= s2_info_r.last;
    end
  end

  mmf_seq #(.MAX_LINE(MAX_LINE)) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (accept),
    .len_cfg (len_r),
    .hgt_cfg (hgt_r),
    .col     (seq_col),
    .info    (seq_info)
  );

  mmf_linebuf #(.MAX_LINE(MAX_LINE), .PIXEL_BITS(PIXEL_BITS)) u_linebuf (
    .clk    (clk),
    .rd_en  (accept),
    .rd_col (seq_col),
    .wr_en  (s1_go),
    .wr_col (s1_col_r),
    .wr_px  (s1_px_r),
    .top_px (top_px),
    .mid_px (mid_px)
  );

  mmf_kernel #(.PIXEL_BITS(PIXEL_BITS)) u_kernel (
    .clk        (clk),
    .rst_n      (rst_n),
    .shift      (s1_go),
    .top_px     (top_px),
    .mid_px     (mid_px),
    .new_px     (s1_px_r),
    .mode       (mode_r),
    .mask_shape (mask_r),
    .fill_value (fill_r),
    .border     (s2_info_r.border),
    .result     (kern_res)
  );

  assign out_px.valid     = out_v_r;
  assign out_px.pixel_out = out_px_r;
  assign out_px.frame_end = out_end_r;

endmodule

// ===== hdl/mmf_seq.sv =====
// Raster position counters: column, output row and frame start-up count
module mmf_seq #(
  parameter int MAX_LINE = 1024,
  localparam int COL_W = $clog2(MAX_LINE)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                adv,
  input  logic [mmf_pkg::LINE_LEN_W-1:0]      len_cfg,
  input  logic [mmf_pkg::FRAME_H_W-1:0]       hgt_cfg,
  output logic [COL_W-1:0]                    col,
  output mmf_pkg::pos_info_t                  info
);

  localparam int LW    = $clog2(MAX_LINE + 2);
  localparam int CMP_W = (LW > mmf_pkg::LINE_LEN_W) ? LW : mmf_pkg::LINE_LEN_W;
  localparam int HW    = mmf_pkg::FRAME_H_W;

  logic [COL_W-1:0] col_r, col_nxt;
  logic [HW-1:0]    row_r, row_nxt;
  logic [LW-1:0]    started_r, started_nxt;

  logic [CMP_W-1:0] len_ext;
  logic [LW-1:0]    len_c, col_ext, col_inc, ocol;
  logic [HW-1:0]    hgt_c;
  logic             priming, eol, last_row;

  // Clamp the geometry
  always_comb begin
    len_ext = CMP_W'(len_cfg);
    if (len_ext < CMP_W'(mmf_pkg::MIN_GEOM)) begin
      len_c = LW'(mmf_pkg::MIN_GEOM);
    end else if (len_ext > CMP_W'(MAX_LINE)) begin
      len_c = LW'(MAX_LINE);
    end else begin
      len_c = len_ext[LW-1:0];
    end
    hgt_c = (hgt_cfg < HW'(mmf_pkg::MIN_GEOM)) ? HW'(mmf_pkg::MIN_GEOM) : hgt_cfg;
  end

  // Position of the output pixel, one row plus one pixel back
  always_comb begin
    col_ext  = LW'(col_r);
    col_inc  = col_ext + LW'(1);
    priming  = started_r < (len_c + LW'(1));
    ocol     = (col_r == '0) ? (len_c - LW'(1)) : (col_ext - LW'(1));
    eol      = ocol >= (len_c - LW'(1));
    last_row = row_r >= (hgt_c - HW'(1));
    info.emit   = !priming;
    info.border = (row_r == '0) || last_row || (ocol == '0) || eol;
    info.last   = last_row && eol;
  end

  // Advance counters on every accepted beat
  always_comb begin
    col_nxt     = col_r;
    row_nxt     = row_r;
    started_nxt = started_r;
    if (adv) begin
      col_nxt = (col_inc >= len_c) ? '0 : col_inc[COL_W-1:0];
      if (priming) begin
        started_nxt = started_r + LW'(1);
      end else if (info.last) begin
        col_nxt     = '0;
        row_nxt     = '0;
        started_nxt = '0;
      end else if (eol) begin
        row_nxt = row_r + HW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      started_r <= '0;
    end else begin
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      started_r <= started_nxt;
    end
  end

  assign col = col_r;

endmodule

// ===== hdl/mmf_linebuf.sv =====
// Two row stores (row above, two rows above) with write-to-read bypass
module mmf_linebuf #(
  parameter int MAX_LINE   = 1024,
  parameter int PIXEL_BITS = 16,
  localparam int COL_W = $clog2(MAX_LINE)
) (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic [COL_W-1:0]             rd_col,
  input  logic                         wr_en,
  input  logic [COL_W-1:0]             wr_col,
  input  logic signed [PIXEL_BITS-1:0] wr_px,
  output logic signed [PIXEL_BITS-1:0] top_px,
  output logic signed [PIXEL_BITS-1:0] mid_px
);

  logic signed [PIXEL_BITS-1:0] mid_ram [MAX_LINE];
  logic signed [PIXEL_BITS-1:0] top_ram [MAX_LINE];

  logic signed [PIXEL_BITS-1:0] mid_q_r, top_q_r, fwd_mid_r, fwd_top_r;
  logic                         fwd_r;

  // Read both rows for the incoming beat; bypass the write that lands in the same cycle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      mid_q_r   <= mid_ram[rd_col];
      top_q_r   <= top_ram[rd_col];
      fwd_r     <= wr_en && (rd_col == wr_col);
      fwd_mid_r <= wr_px;
      fwd_top_r <= mid_px;
    end
  end

  // Shift the column down one row as its beat leaves the first stage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mid_ram[wr_col] <= wr_px;
      top_ram[wr_col] <= mid_px;
    end
  end

  assign mid_px = fwd_r ? fwd_mid_r : mid_q_r;
  assign top_px = fwd_r ? fwd_top_r : top_q_r;

endmodule

// ===== hdl/mmf_kernel.sv =====
// 3x3 window registers and masked min/max with outline subtraction
module mmf_kernel #(
  parameter int PIXEL_BITS = 16
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    shift,
  input  logic signed [PIXEL_BITS-1:0]            top_px,
  input  logic signed [PIXEL_BITS-1:0]            mid_px,
  input  logic signed [PIXEL_BITS-1:0]            new_px,
  input  mmf_pkg::mode_t                          mode,
  input  logic [mmf_pkg::MASK_W-1:0]              mask_shape,
  input  logic signed [mmf_pkg::CFG_DATA_W-1:0]   fill_value,
  input  logic                                    border,
  output logic signed [mmf_pkg::PIX_IO_W-1:0]     result
);

  localparam int OW = mmf_pkg::PIX_IO_W;
  localparam int NT = mmf_pkg::WIN_TAPS;

  logic signed [PIXEL_BITS-1:0] win_r [NT];

  logic [NT-1:0]            msk;
  logic                     is_min;
  logic signed [OW-1:0]     init, acc, center, diff, raw;
  logic signed [OW-1:0]     tap [NT];
  logic signed [OW-1:0]     l1 [5];
  logic signed [OW-1:0]     l2 [3];
  logic signed [OW-1:0]     l3 [2];
  logic [PIXEL_BITS-1:0]    wrapped;

  function automatic logic signed [OW-1:0] pick(input logic signed [OW-1:0] a,
                                                input logic signed [OW-1:0] b,
                                                input logic                 lo);
    if (lo) begin
      return (a < b) ? a : b;
    end
    return (a > b) ? a : b;
  endfunction

  // Shift the window left, new column on the right
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NT; k++) begin
        win_r[k] <= '0;
      end
    end else if (shift) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r*3]     <= win_r[r*3 + 1];
        win_r[r*3 + 1] <= win_r[r*3 + 2];
      end
      win_r[2] <= top_px;
      win_r[5] <= mid_px;
      win_r[8] <= new_px;
    end
  end

  // Masked taps; a masked-off tap takes the starting value and drops out
  always_comb begin
    msk    = mmf_pkg::mask_bits(mask_shape);
    is_min = (mode == mmf_pkg::MODE_ERODE) || (mode == mmf_pkg::MODE_INNER);
    init   = is_min ? fill_value : '0;
    for (int k = 0; k < NT; k++) begin
      tap[k] = msk[k] ? OW'(win_r[k]) : init;
    end
  end

  // Reduce ten values in four levels
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      l1[k] = pick(tap[2*k], tap[2*k + 1], is_min);
    end
    l1[4] = pick(tap[8], init, is_min);
    l2[0] = pick(l1[0], l1[1], is_min);
    l2[1] = pick(l1[2], l1[3], is_min);
    l2[2] = l1[4];
    l3[0] = pick(l2[0], l2[1], is_min);
    l3[1] = l2[2];
    acc   = pick(l3[0], l3[1], is_min);
  end

  // Select the mode result, then wrap to the pixel width
  always_comb begin
    center = OW'(win_r[mmf_pkg::CENTER_TAP]);
    diff   = (mode == mmf_pkg::MODE_INNER) ? (center - acc) : (acc - center);
    unique case (mode)
      mmf_pkg::MODE_ERODE, mmf_pkg::MODE_DILATE: raw = border ? center : acc;
      default:                                   raw = border ? '0 : diff;
    endcase
    wrapped = raw[PIXEL_BITS-1:0];
    result  = OW'($signed(wrapped));
  end

endmodule

// ===== hdl/mmf_checker.sv =====
// Port-level checks for the morphology filter, bound to the top level
`include "masked_3x3_morphology_filter_unit_defines.svh"

module mmf_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [mmf_pkg::PIX_IO_W-1:0]   out_pixel,
  input logic                           out_frame_end
);

  // A held result keeps its data
  `MMF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_pixel) && $stable(out_frame_end), "result changed while stalled")

  // Input side never stalls unless the output is blocked
  `MMF_ASSERT_NOW(a_no_idle_stall, !(out_valid && !out_ready), in_ready, "input stalled with free output")

  // A new frame needs a row plus one pixel before its first result
  `MMF_ASSERT_NEXT(a_frame_gap, out_valid && out_ready && out_frame_end, !out_valid ##1 !out_valid, "result too soon after frame end")

endmodule

bind masked_3x3_morphology_filter_unit mmf_checker u_mmf_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_px.valid),
  .in_ready      (in_px.ready),
  .out_valid     (out_px.valid),
  .out_ready     (out_px.ready),
  .out_pixel     (out_px.pixel_out),
  .out_frame_end (out_px.frame_end)
);
